// ===== rtl/acmc_pkg.sv =====
`default_nettype none

package acmc_pkg;

    // Event kinds carried on the input channel.
    typedef enum logic [1:0] {
        CMD_SCAN = 2'd0,
        CMD_MODE = 2'd1,
        CMD_UP   = 2'd2,
        CMD_DOWN = 2'd3
    } cmd_t;

    // Operating mode, held one-hot.
    typedef enum logic [5:0] {
        MODE_SHOW      = 6'b000001,
        MODE_SET_HOUR  = 6'b000010,
        MODE_SET_MIN   = 6'b000100,
        MODE_ALM_HOUR  = 6'b001000,
        MODE_ALM_MIN   = 6'b010000,
        MODE_RING      = 6'b100000
    } mode_t;

    // Mode codes as reported on the result channel.
    localparam logic [2:0] MODE_CODE_SHOW     = 3'd0;
    localparam logic [2:0] MODE_CODE_SET_HOUR = 3'd1;
    localparam logic [2:0] MODE_CODE_SET_MIN  = 3'd2;
    localparam logic [2:0] MODE_CODE_ALM_HOUR = 3'd3;
    localparam logic [2:0] MODE_CODE_ALM_MIN  = 3'd4;
    localparam logic [2:0] MODE_CODE_RING     = 3'd5;

    // Pending adjustment requests.
    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_UP   = 2'd1,
        ADJ_DOWN = 2'd2
    } adj_t;

    localparam logic [5:0] ASCII_ZERO     = 6'h30;
    localparam logic [5:0] HOURS_PER_DAY  = 6'd24;
    localparam logic [6:0] MINS_PER_HOUR  = 7'd60;
    localparam logic [4:0] HOUR_MAX       = 5'd23;
    localparam logic [5:0] MINUTE_MAX     = 6'd59;
    localparam logic [3:0] BEEP_RING      = 4'd8;
    localparam logic [3:0] BEEP_ALARM_SET = 4'd5;
    localparam logic [3:0] BEEP_KEY       = 4'd1;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    typedef struct packed {
        cmd_t        command;
        logic [4:0]  rtc_hour;
        logic [5:0]  rtc_minute;
        logic        blink_on;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  digit_hour_tens;
        logic [5:0]  digit_hour_ones;
        logic [5:0]  digit_minute_tens;
        logic [5:0]  digit_minute_ones;
        logic        rtc_write;
        logic [4:0]  write_hour;
        logic [5:0]  write_minute;
        logic        beep;
        logic        alarm_armed;
        logic        ringing;
        logic [2:0]  mode;
        logic [1:0]  scan_index;
    } result_t;

    // Hour step with wrap over a day; above 23, an up step subtracts 24 and a down step does not wrap.
    function automatic logic [4:0] hour_adjust(input logic [4:0] v, input adj_t req);
        logic [5:0] inc;
        logic [5:0] wrapped;
        inc = {1'b0, v} + 6'd1;
        wrapped = (inc >= HOURS_PER_DAY) ? (inc - HOURS_PER_DAY) : inc;
        case (req)
            ADJ_UP:   hour_adjust = wrapped[4:0];
            ADJ_DOWN: hour_adjust = (v == 5'd0) ? HOUR_MAX : (v - 5'd1);
            default:  hour_adjust = v;
        endcase
    endfunction

    function automatic logic [5:0] minute_adjust(input logic [5:0] v, input adj_t req);
        logic [6:0] inc;
        logic [6:0] wrapped;
        inc = {1'b0, v} + 7'd1;
        wrapped = (inc >= MINS_PER_HOUR) ? (inc - MINS_PER_HOUR) : inc;
        case (req)
            ADJ_UP:   minute_adjust = wrapped[5:0];
            ADJ_DOWN: minute_adjust = (v == 6'd0) ? MINUTE_MAX : (v - 6'd1);
            default:  minute_adjust = v;
        endcase
    endfunction

    function automatic logic [2:0] mode_code(input mode_t m);
        case (m)
            MODE_SET_HOUR: mode_code = MODE_CODE_SET_HOUR;
            MODE_SET_MIN:  mode_code = MODE_CODE_SET_MIN;
            MODE_ALM_HOUR: mode_code = MODE_CODE_ALM_HOUR;
            MODE_ALM_MIN:  mode_code = MODE_CODE_ALM_MIN;
            MODE_RING:     mode_code = MODE_CODE_RING;
            default:       mode_code = MODE_CODE_SHOW;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/acmc_pair.sv =====
`default_nettype none

// Turns a two-digit value into a pair of ASCII digits, or zeros when blanked.
module acmc_pair (
    input  wire logic [5:0] value,
    input  wire logic       shown,
    output logic      [5:0] tens,
    output logic      [5:0] ones
);

    logic [13:0] scaled;
    logic [2:0]  quot;
    logic [5:0]  rem;

    // value / 10 as a reciprocal multiply, exact for all six-bit values.
    assign scaled = {8'd0, value} * 14'd205;
    assign quot   = scaled[13:11];
    assign rem    = value - ({3'd0, quot} * 6'd10);

    assign tens = shown ? (acmc_pkg::ASCII_ZERO + {3'd0, quot}) : 6'd0;
    assign ones = shown ? (acmc_pkg::ASCII_ZERO + rem) : 6'd0;

endmodule

`default_nettype wire

// ===== rtl/acmc_core.sv =====
`default_nettype none

// Controller state and the per-event mode pass.
module acmc_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire acmc_pkg::in_item_t item,
    output acmc_pkg::result_t       result
);

    acmc_pkg::mode_t mode_reg, mode_next;
    logic [4:0]      edit_hour_reg, edit_hour_next;
    logic [5:0]      edit_minute_reg, edit_minute_next;
    logic [4:0]      alarm_hour_reg, alarm_hour_next;
    logic [5:0]      alarm_minute_reg, alarm_minute_next;
    logic            armed_reg, armed_next;
    logic            ring_reg, ring_next;
    acmc_pkg::adj_t  adjust_reg, adjust_next;
    logic [3:0]      beep_count_reg, beep_count_next;
    logic [1:0]      scan_pos_reg, scan_pos_next;
    logic            beep_level_reg, beep_level_next;

    logic       reload;
    logic [5:0] hour_val, minute_val;
    logic       hour_shown, minute_shown;
    logic       wr;
    logic [4:0] wh;
    logic [5:0] wm;

    always_comb begin
        mode_next         = mode_reg;
        edit_hour_next    = edit_hour_reg;
        edit_minute_next  = edit_minute_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        armed_next        = armed_reg;
        ring_next         = ring_reg;
        adjust_next       = adjust_reg;
        beep_count_next   = beep_count_reg;
        scan_pos_next     = scan_pos_reg;
        beep_level_next   = beep_level_reg;
        reload            = 1'b0;

        case (item.command)
            acmc_pkg::CMD_SCAN: begin
                scan_pos_next = scan_pos_reg + 2'd1;
                if (armed_reg && (item.rtc_hour == alarm_hour_reg) &&
                    (item.rtc_minute == alarm_minute_reg)) begin
                    ring_next = 1'b1;
                end
                if (beep_count_reg != 4'd0) begin
                    beep_level_next = 1'b1;
                    beep_count_next = beep_count_reg - 4'd1;
                end else begin
                    beep_level_next = 1'b0;
                end
            end
            acmc_pkg::CMD_MODE: begin
                case (mode_reg)
                    acmc_pkg::MODE_SHOW:     mode_next = acmc_pkg::MODE_SET_HOUR;
                    acmc_pkg::MODE_SET_HOUR: mode_next = acmc_pkg::MODE_SET_MIN;
                    acmc_pkg::MODE_ALM_HOUR: mode_next = acmc_pkg::MODE_ALM_MIN;
                    acmc_pkg::MODE_RING:     mode_next = acmc_pkg::MODE_RING;
                    default:                 mode_next = acmc_pkg::MODE_SHOW;
                endcase
                reload          = 1'b1;
                beep_count_next = acmc_pkg::BEEP_KEY;
            end
            acmc_pkg::CMD_UP: begin
                if (mode_reg != acmc_pkg::MODE_SHOW) begin
                    adjust_next = acmc_pkg::ADJ_UP;
                end else begin
                    mode_next       = acmc_pkg::MODE_ALM_HOUR;
                    reload          = 1'b1;
                    beep_count_next = acmc_pkg::BEEP_ALARM_SET;
                end
            end
            acmc_pkg::CMD_DOWN: begin
                if (mode_reg == acmc_pkg::MODE_RING) begin
                    ring_next  = 1'b0;
                    armed_next = 1'b0;
                end else if (mode_reg == acmc_pkg::MODE_SHOW) begin
                    armed_next = ~armed_reg;
                end else begin
                    adjust_next = acmc_pkg::ADJ_DOWN;
                end
            end
            default: begin
            end
        endcase

        if (reload) begin
            edit_hour_next   = item.rtc_hour;
            edit_minute_next = item.rtc_minute;
        end
        if (ring_next) begin
            mode_next = acmc_pkg::MODE_RING;
        end

        hour_val     = {1'b0, item.rtc_hour};
        minute_val   = item.rtc_minute;
        hour_shown   = 1'b1;
        minute_shown = 1'b1;
        wr           = 1'b0;
        wh           = 5'd0;
        wm           = 6'd0;

        case (mode_next)
            acmc_pkg::MODE_SET_HOUR: begin
                hour_val       = {1'b0, edit_hour_next};
                hour_shown     = item.blink_on;
                edit_hour_next = acmc_pkg::hour_adjust(edit_hour_next, adjust_next);
                adjust_next    = acmc_pkg::ADJ_NONE;
                wr             = 1'b1;
                wh             = edit_hour_next;
                wm             = item.rtc_minute;
            end
            acmc_pkg::MODE_SET_MIN: begin
                minute_val       = edit_minute_next;
                minute_shown     = item.blink_on;
                edit_minute_next = acmc_pkg::minute_adjust(edit_minute_next, adjust_next);
                adjust_next      = acmc_pkg::ADJ_NONE;
                wr               = 1'b1;
                wh               = item.rtc_hour;
                wm               = edit_minute_next;
            end
            acmc_pkg::MODE_ALM_HOUR: begin
                hour_val        = {1'b0, alarm_hour_next};
                hour_shown      = item.blink_on;
                alarm_hour_next = acmc_pkg::hour_adjust(alarm_hour_next, adjust_next);
                adjust_next     = acmc_pkg::ADJ_NONE;
            end
            acmc_pkg::MODE_ALM_MIN: begin
                minute_val        = alarm_minute_next;
                minute_shown      = item.blink_on;
                alarm_minute_next = acmc_pkg::minute_adjust(alarm_minute_next, adjust_next);
                adjust_next       = acmc_pkg::ADJ_NONE;
            end
            acmc_pkg::MODE_RING: begin
                hour_shown      = item.blink_on;
                minute_shown    = item.blink_on;
                beep_count_next = acmc_pkg::BEEP_RING;
                if (!ring_next) begin
                    mode_next = acmc_pkg::MODE_SHOW;
                end
            end
            default: begin
            end
        endcase
    end

    acmc_pair u_hour_pair (
        .value (hour_val),
        .shown (hour_shown),
        .tens  (result.digit_hour_tens),
        .ones  (result.digit_hour_ones)
    );

    acmc_pair u_minute_pair (
        .value (minute_val),
        .shown (minute_shown),
        .tens  (result.digit_minute_tens),
        .ones  (result.digit_minute_ones)
    );

    assign result.rtc_write    = wr;
    assign result.write_hour   = wh;
    assign result.write_minute = wm;
    assign result.beep         = beep_level_next;
    assign result.alarm_armed  = armed_next;
    assign result.ringing      = ring_next;
    assign result.mode         = acmc_pkg::mode_code(mode_next);
    assign result.scan_index   = scan_pos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= acmc_pkg::MODE_SHOW;
            edit_hour_reg    <= 5'd0;
            edit_minute_reg  <= 6'd0;
            alarm_hour_reg   <= 5'd0;
            alarm_minute_reg <= 6'd0;
            armed_reg        <= 1'b0;
            ring_reg         <= 1'b0;
            adjust_reg       <= acmc_pkg::ADJ_NONE;
            beep_count_reg   <= 4'd0;
            scan_pos_reg     <= 2'd0;
            beep_level_reg   <= 1'b0;
        end else if (en) begin
            mode_reg         <= mode_next;
            edit_hour_reg    <= edit_hour_next;
            edit_minute_reg  <= edit_minute_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            armed_reg        <= armed_next;
            ring_reg         <= ring_next;
            adjust_reg       <= adjust_next;
            beep_count_reg   <= beep_count_next;
            scan_pos_reg     <= scan_pos_next;
            beep_level_reg   <= beep_level_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/alarm_clock_mode_controller.sv =====
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle; the input register, the mode logic and the result
// register form a two-stage pipeline that advances whenever the result slot is free.
// Reset: aresetn is synchronous and active low; it clears the mode to show time,
// all edit and alarm values, the flags, the beep countdown and the scan position.
`default_nettype none

module alarm_clock_mode_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, from bit 0: rtc_hour[4:0], rtc_minute[10:5], blink_on[11], zeros[15:12]
    input  wire logic [acmc_pkg::IN_TDATA_W-1:0] s_tdata,
    // s_tuser: command[1:0] (scan tick, mode key, up key, down key)
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, from bit 0: digit_hour_tens[5:0], digit_hour_ones[11:6],
    // digit_minute_tens[17:12], digit_minute_ones[23:18], rtc_write[24],
    // write_hour[29:25], write_minute[35:30], beep[36], alarm_armed[37],
    // ringing[38], mode[41:39], scan_index[43:42], zeros[47:44]
    output logic [47:0]      m_tdata
);

    // Input stage. An item waits here until the result register can take its result.
    logic                in_valid_reg, in_valid_next;
    acmc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    logic [acmc_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic                s_accept;
    logic                advance;
    acmc_pkg::result_t   result;

    // The mode pass runs, and the state moves on, only when the result slot is
    // empty or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.command    <= acmc_pkg::cmd_t'(s_tuser);
            in_item_reg.rtc_hour   <= s_tdata[4:0];
            in_item_reg.rtc_minute <= s_tdata[10:5];
            in_item_reg.blink_on   <= s_tdata[11];
        end
    end

    acmc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // Result register: fields packed from the lowest bit up.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {4'd0,
                             result.scan_index,
                             result.mode,
                             result.ringing,
                             result.alarm_armed,
                             result.beep,
                             result.write_minute,
                             result.write_hour,
                             result.rtc_write,
                             result.digit_minute_ones,
                             result.digit_minute_tens,
                             result.digit_hour_ones,
                             result.digit_hour_tens};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/acmc_checker.sv =====
`default_nettype none

module acmc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    logic       unused_in;
    logic       rtc_write;
    logic [10:0] write_fields;
    logic       armed;
    logic       ringing;
    logic [2:0] mode;

    assign unused_in    = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);
    assign rtc_write    = m_tdata[24];
    assign write_fields = m_tdata[35:25];
    assign armed        = m_tdata[37];
    assign ringing      = m_tdata[38];
    assign mode         = m_tdata[41:39];

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // No result is presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A clock write is requested only from the hour and minute clock set modes, else it is zero.
    a_write_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rtc_write && (mode == acmc_pkg::MODE_CODE_SET_HOUR ||
                                    mode == acmc_pkg::MODE_CODE_SET_MIN)) ||
                     (!rtc_write && write_fields == 11'd0 && !unused_in) ||
                     (!rtc_write && write_fields == 11'd0 && unused_in))
        else $error("clock write outside a set mode");

    // The ringing flag and the ringing mode always agree.
    a_ring_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ringing == (mode == acmc_pkg::MODE_CODE_RING)))
        else $error("ringing flag and mode disagree");

    // Ringing can only come from an armed alarm and dismissal disarms both.
    a_ring_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ringing |-> armed)
        else $error("ringing while the alarm is not armed");

endmodule

bind alarm_clock_mode_controller acmc_checker u_acmc_checker (.*);

`default_nettype wire
